// ----- design/wlc_pkg.sv -----
// ----------------------------------------------------------------------------
// wlc_pkg
// Shared types and constants for the size-weighted LRU cache.
// ----------------------------------------------------------------------------
package wlc_pkg;

    localparam int ENTRIES   = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int BUF_DEPTH = ENTRIES + 1;
    localparam int BUF_W     = $clog2(BUF_DEPTH);
    localparam int Q_DEPTH   = 2;
    localparam int Q_W       = $clog2(Q_DEPTH);

    localparam logic [19:0] LIMIT_RESET = 20'd65536;

    localparam logic [1:0] REQ_GET      = 2'd0;
    localparam logic [1:0] REQ_PUT      = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [2:0] KIND_RELEASE    = 3'd0;
    localparam logic [2:0] KIND_HIT        = 3'd1;
    localparam logic [2:0] KIND_MISS       = 3'd2;
    localparam logic [2:0] KIND_PUT_DONE   = 3'd3;
    localparam logic [2:0] KIND_PUT_REJECT = 3'd4;
    localparam logic [2:0] KIND_CLEAR_DONE = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        text_present;
        logic [7:0]  role_id;
        logic [31:0] text_color;
        logic [31:0] text_key;
        logic [31:0] value_handle;
        logic [19:0] entry_bytes;
    } wlc_req_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] out_value;
        logic [19:0] total_bytes;
        logic [5:0]  entry_count;
        logic        last_result;
    } wlc_rsp_t;

    typedef enum logic [1:0] {
        OP_GET,
        OP_PUT,
        OP_REJECT,
        OP_CLEAR
    } wlc_op_t;

    typedef struct packed {
        wlc_op_t     op;
        logic        present;
        logic [7:0]  role_id;
        logic [31:0] color;
        logic [31:0] key;
        logic [31:0] value;
        logic [19:0] nbytes;
    } wlc_cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
    } wlc_buf_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PUT_UPD,
        ST_EVICT,
        ST_FINISH,
        ST_DRAIN
    } wlc_state_t;

endpackage

// ----- design/wlc_front.sv -----
// ----------------------------------------------------------------------------
// wlc_front
// Accepts request words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module wlc_front
    import wlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  wlc_req_t    req,
    input  logic [19:0] byte_limit,
    output logic        cmd_valid,
    output wlc_cmd_t    cmd,
    input  logic        cmd_pop
);

    wlc_cmd_t       q_mem [Q_DEPTH];
    logic [Q_W-1:0] wr_ptr_reg;
    logic [Q_W-1:0] rd_ptr_reg;
    logic [Q_W:0]   cnt_reg;
    wlc_cmd_t       cls;
    logic           push;
    logic           pop;

    assign busy      = (cnt_reg == (Q_W + 1)'(Q_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    // reserved request type is taken and dropped
    assign push      = start && !busy && (req.req_type != REQ_RESERVED);
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        cls.present   = req.text_present;
        cls.role_id   = req.role_id;
        cls.color     = req.text_color;
        cls.key       = req.text_key;
        cls.value     = req.value_handle;
        cls.nbytes    = req.entry_bytes;
        case (req.req_type)
            REQ_GET:   cls.op = OP_GET;
            REQ_PUT:   cls.op = (!req.text_present || req.entry_bytes > byte_limit)
                                ? OP_REJECT : OP_PUT;
            REQ_CLEAR: cls.op = OP_CLEAR;
            default:   cls.op = OP_GET;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push && pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/wlc_back.sv -----
// ----------------------------------------------------------------------------
// wlc_back
// Slot store, LRU ranking, eviction sequencer and result buffer.
// ----------------------------------------------------------------------------
module wlc_back
    import wlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [19:0] byte_limit,
    input  logic        cmd_valid,
    input  wlc_cmd_t    cmd,
    output logic        cmd_pop,
    output logic        rsp_valid,
    output wlc_rsp_t    rsp
);

    logic [ENTRIES-1:0] valid_reg;
    logic [7:0]         role_reg  [ENTRIES];
    logic [31:0]        color_reg [ENTRIES];
    logic [31:0]        key_reg   [ENTRIES];
    logic [31:0]        value_reg [ENTRIES];
    logic [19:0]        size_reg  [ENTRIES];
    logic [IDX_W-1:0]   rank_reg  [ENTRIES];
    logic [19:0]        held_reg;
    logic [CNT_W-1:0]   count_reg;

    wlc_state_t         state_reg, state_next;
    wlc_cmd_t           cmd_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;

    wlc_buf_t           buf_mem [BUF_DEPTH];
    logic [BUF_W-1:0]   wr_cnt_reg;
    logic [BUF_W-1:0]   rd_addr_reg;
    wlc_buf_t           rd_data_reg;
    logic               out_valid_reg;
    logic               out_last_reg;
    logic [19:0]        out_bytes_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic [ENTRIES-1:0] match;
    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic [ENTRIES-1:0] victim;
    logic [IDX_W-1:0]   victim_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   tail_rank;
    logic               evict_need;

    logic               do_load;
    logic               do_lookup;
    logic               do_put_upd;
    logic               do_evict;
    logic               do_finish;
    logic               do_insert;
    logic               do_promote;
    logic               do_issue;
    logic               push;
    wlc_buf_t           push_data;

    // associative compare over every slot
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && cmd_reg.present && role_reg[i] == cmd_reg.role_id
                       && color_reg[i] == cmd_reg.color && key_reg[i] == cmd_reg.key;
        end
    end

    assign tail_rank = IDX_W'(count_reg - 1'b1);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            victim[i] = valid_reg[i] && (rank_reg[i] == tail_rank);
        end
    end

    always_comb
    begin
        hit_any    = 1'b0;
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (victim[i])
            begin
                victim_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // put never reaches here with nbytes above the limit, so no underflow
    assign evict_need = (count_reg != '0) &&
                        (cmd_reg.op == OP_CLEAR ||
                         held_reg > (byte_limit - cmd_reg.nbytes) ||
                         (!hit_reg && count_reg >= CNT_W'(ENTRIES)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        do_load    = 1'b0;
        do_lookup  = 1'b0;
        do_put_upd = 1'b0;
        do_evict   = 1'b0;
        do_finish  = 1'b0;
        do_insert  = 1'b0;
        do_promote = 1'b0;
        do_issue   = 1'b0;
        push       = 1'b0;
        push_data  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    do_load    = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                do_lookup = 1'b1;
                if (cmd_reg.op == OP_PUT && hit_any)
                begin
                    state_next = ST_PUT_UPD;
                end
                else if (cmd_reg.op == OP_PUT || cmd_reg.op == OP_CLEAR)
                begin
                    state_next = ST_EVICT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PUT_UPD:
            begin
                do_put_upd = 1'b1;
                do_promote = 1'b1;
                if (value_reg[hit_idx_reg] != cmd_reg.value)
                begin
                    push      = 1'b1;
                    push_data = '{kind: KIND_RELEASE, value: value_reg[hit_idx_reg]};
                end
                state_next = ST_EVICT;
            end
            ST_EVICT:
            begin
                if (evict_need)
                begin
                    do_evict  = 1'b1;
                    push      = 1'b1;
                    push_data = '{kind: KIND_RELEASE, value: value_reg[victim_idx]};
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                do_finish  = 1'b1;
                push       = 1'b1;
                state_next = ST_DRAIN;
                case (cmd_reg.op)
                    OP_GET:
                    begin
                        if (hit_reg)
                        begin
                            do_promote = 1'b1;
                            push_data  = '{kind: KIND_HIT, value: value_reg[hit_idx_reg]};
                        end
                        else
                        begin
                            push_data = '{kind: KIND_MISS, value: 32'd0};
                        end
                    end
                    OP_PUT:
                    begin
                        do_insert = !hit_reg;
                        push_data = '{kind: KIND_PUT_DONE, value: 32'd0};
                    end
                    OP_REJECT: push_data = '{kind: KIND_PUT_REJECT, value: 32'd0};
                    OP_CLEAR:  push_data = '{kind: KIND_CLEAR_DONE, value: 32'd0};
                    default:   push_data = '{kind: KIND_MISS, value: 32'd0};
                endcase
            end
            ST_DRAIN:
            begin
                do_issue = 1'b1;
                if (rd_addr_reg == wr_cnt_reg - 1'b1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            cmd_reg <= cmd;
        end
        if (do_lookup)
        begin
            hit_idx_reg <= hit_idx;
        end
        if (do_put_upd)
        begin
            value_reg[hit_idx_reg] <= cmd_reg.value;
            size_reg[hit_idx_reg]  <= cmd_reg.nbytes;
        end
        if (do_insert)
        begin
            role_reg[free_idx]  <= cmd_reg.role_id;
            color_reg[free_idx] <= cmd_reg.color;
            key_reg[free_idx]   <= cmd_reg.key;
            value_reg[free_idx] <= cmd_reg.value;
            size_reg[free_idx]  <= cmd_reg.nbytes;
        end
        // ranks stay dense, so dropping the tail needs no renumbering
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (do_promote)
            begin
                if (IDX_W'(i) == hit_idx_reg)
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i] && rank_reg[i] < rank_reg[hit_idx_reg])
                begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
            else if (do_insert)
            begin
                if (IDX_W'(i) == free_idx)
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i])
                begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
        end
        if (push)
        begin
            buf_mem[wr_cnt_reg] <= push_data;
        end
        if (do_issue)
        begin
            rd_data_reg   <= buf_mem[rd_addr_reg];
            out_last_reg  <= (rd_addr_reg == wr_cnt_reg - 1'b1);
            out_bytes_reg <= held_reg;
            out_count_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            held_reg      <= '0;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            wr_cnt_reg    <= '0;
            rd_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= do_issue;
            if (do_load)
            begin
                wr_cnt_reg <= '0;
            end
            else if (push)
            begin
                wr_cnt_reg <= wr_cnt_reg + 1'b1;
            end
            if (do_finish)
            begin
                rd_addr_reg <= '0;
            end
            else if (do_issue)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
            if (do_lookup)
            begin
                hit_reg <= hit_any;
            end
            if (do_put_upd)
            begin
                held_reg <= held_reg - size_reg[hit_idx_reg];
            end
            else if (do_evict)
            begin
                held_reg                <= held_reg - size_reg[victim_idx];
                valid_reg[victim_idx]   <= 1'b0;
                count_reg               <= count_reg - 1'b1;
            end
            else if (do_finish && cmd_reg.op == OP_PUT)
            begin
                held_reg <= held_reg + cmd_reg.nbytes;
                if (do_insert)
                begin
                    valid_reg[free_idx] <= 1'b1;
                    count_reg           <= count_reg + 1'b1;
                end
            end
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp.result_kind   = rd_data_reg.kind;
    assign rsp.out_value     = rd_data_reg.value;
    assign rsp.total_bytes   = out_bytes_reg;
    assign rsp.entry_count   = 6'(out_count_reg);
    assign rsp.last_result   = out_last_reg;

endmodule

// ----- design/weighted_lru_cache_top.sv -----
// ----------------------------------------------------------------------------
// weighted_lru_cache_top
// Fully associative LRU cache with a byte budget and per-item result stream.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a word on req is taken at a clock edge with start high
//   and busy low. A two-deep queue sits behind the port, so busy rises only
//   when two words wait for the engine.
//   Result channel: each result word is on rsp for one cycle with rsp_valid
//   high; the receiver cannot stall it. Released handles come first, the
//   status word last with last_result set. All words of one request carry
//   the byte total and entry count left after that request.
//   cfg_we/cfg_wdata write byte_limit; write it only while the block is idle.
// Sequence per request (single eviction sequencer in the engine):
//   load and lookup; a put that hits updates its slot; put and clear drop
//   least recently used entries one at a time as needed; then finish and
//   drain the result words. First result appears in the cycle after the
//   drain starts. Reserved request type is taken with no result.
// Reset: all entries invalid, totals zero, byte_limit 65536.
// ----------------------------------------------------------------------------
module weighted_lru_cache_top
    import wlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  wlc_req_t    req,
    output logic        rsp_valid,
    output wlc_rsp_t    rsp,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata
);

    logic [19:0] limit_reg;
    logic        cmd_valid;
    logic        cmd_pop;
    wlc_cmd_t    cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    wlc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .byte_limit (limit_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    wlc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_limit (limit_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp)
    );

endmodule

// ----- design/wlc_checker.sv -----
// ----------------------------------------------------------------------------
// wlc_checker
// Port-level checks on the result stream of the cache.
// ----------------------------------------------------------------------------
module wlc_checker
    import wlc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rsp_valid,
    input  wlc_rsp_t rsp
);

    // released handles are never the final word
    a_release_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind == KIND_RELEASE |-> !rsp.last_result)
        else $error("release word marked last");

    // every status word closes its request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind != KIND_RELEASE |-> rsp.last_result)
        else $error("status word not marked last");

    // a clear leaves nothing behind
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind == KIND_CLEAR_DONE |->
            rsp.entry_count == 6'd0 && rsp.total_bytes == 20'd0)
        else $error("clear left entries");

    // words of one request carry the same totals
    a_totals_steady: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last_result |=>
            rsp_valid && rsp.total_bytes == $past(rsp.total_bytes)
            && rsp.entry_count == $past(rsp.entry_count))
        else $error("totals changed within a request");

endmodule

bind weighted_lru_cache_top wlc_checker u_wlc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives request words into the weighted LRU cache and checks every result
// word against an in-bench model of the cache's slots, recency and byte total.
// ----------------------------------------------------------------------------
module tb;
    import wlc_pkg::*;

    localparam int MAX_CYCLES = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    wlc_req_t    req;
    logic        rsp_valid;
    wlc_rsp_t    rsp;
    logic        cfg_we;
    logic [19:0] cfg_wdata;

    weighted_lru_cache_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // cache image
    logic [19:0] lim;
    logic        m_valid [ENTRIES];
    logic [7:0]  m_role  [ENTRIES];
    logic [31:0] m_color [ENTRIES];
    logic [31:0] m_key   [ENTRIES];
    logic [31:0] m_value [ENTRIES];
    logic [19:0] m_bytes [ENTRIES];
    int          m_rank  [ENTRIES];
    logic [19:0] m_total;
    int          m_count;

    wlc_rsp_t expected_words[$];
    wlc_rsp_t pend[$];
    int       errors;
    int       idle_pct;
    longint   cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        wlc_rsp_t e;
        if (rst_n && rsp_valid)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word %h", rsp);
            end
            else
            begin
                e = expected_words.pop_front();
                if (rsp !== e)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp kind %0d val %h tot %0d cnt %0d last %b,",
                                  " got kind %0d val %h tot %0d cnt %0d last %b"},
                            e.result_kind, e.out_value, e.total_bytes, e.entry_count,
                            e.last_result, rsp.result_kind, rsp.out_value,
                            rsp.total_bytes, rsp.entry_count, rsp.last_result);
                end
            end
        end
    end

    function automatic int lookup_slot(logic [7:0] r, logic [31:0] c, logic [31:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_role[i] == r && m_color[i] == c && m_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void promote(int s);
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_rank[i] < m_rank[s])
                m_rank[i]++;
        m_rank[s] = 0;
    endfunction

    function automatic void add_word(logic [2:0] kind, logic [31:0] v);
        wlc_rsp_t w;
        w = '0;
        w.result_kind = kind;
        w.out_value = v;
        pend.push_back(w);
    endfunction

    function automatic void drop_oldest();
        int s;
        s = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && (s < 0 || m_rank[i] > m_rank[s]))
                s = i;
        if (s < 0)
            return;
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_rank[i] > m_rank[s])
                m_rank[i]--;
        m_valid[s] = 1'b0;
        m_total = m_total - m_bytes[s];
        m_count--;
        add_word(KIND_RELEASE, m_value[s]);
    endfunction

    function automatic void predict_cache(wlc_req_t q);
        int  s;
        bit  fresh;
        wlc_rsp_t w;
        pend.delete();
        if (q.req_type == REQ_RESERVED)
            return;
        if (q.req_type == REQ_GET)
        begin
            s = q.text_present ? lookup_slot(q.role_id, q.text_color, q.text_key) : -1;
            if (s >= 0)
            begin
                promote(s);
                add_word(KIND_HIT, m_value[s]);
            end
            else
                add_word(KIND_MISS, '0);
        end
        else if (q.req_type == REQ_CLEAR)
        begin
            while (m_count > 0)
                drop_oldest();
            add_word(KIND_CLEAR_DONE, '0);
        end
        else if (!q.text_present || q.entry_bytes > lim)
            add_word(KIND_PUT_REJECT, '0);
        else
        begin
            s = lookup_slot(q.role_id, q.text_color, q.text_key);
            fresh = (s < 0);
            if (!fresh)
            begin
                m_total = m_total - m_bytes[s];
                if (m_value[s] != q.value_handle)
                    add_word(KIND_RELEASE, m_value[s]);
                m_value[s] = q.value_handle;
                m_bytes[s] = q.entry_bytes;
                promote(s);
            end
            while (m_count > 0 && (m_total > lim - q.entry_bytes ||
                   (fresh && m_count >= ENTRIES)))
                drop_oldest();
            if (fresh)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!m_valid[i])
                    begin
                        s = i;
                        break;
                    end
                for (int i = 0; i < ENTRIES; i++)
                    if (m_valid[i])
                        m_rank[i]++;
                m_valid[s] = 1'b1;
                m_role[s] = q.role_id;
                m_color[s] = q.text_color;
                m_key[s] = q.text_key;
                m_value[s] = q.value_handle;
                m_bytes[s] = q.entry_bytes;
                m_rank[s] = 0;
                m_count++;
            end
            m_total = m_total + q.entry_bytes;
            add_word(KIND_PUT_DONE, '0);
        end
        foreach (pend[i])
        begin
            w = pend[i];
            w.total_bytes = m_total;
            w.entry_count = m_count[5:0];
            w.last_result = (i == pend.size() - 1);
            expected_words.push_back(w);
        end
    endfunction

    // start stays high after a send so words can follow back to back
    task automatic send_word(wlc_req_t q);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_cache(q);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        // reserved words never enter the queue and yield no result
        repeat (80) @(posedge clk);
    endtask

    task automatic set_limit(logic [19:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim = v;
    endtask

    function automatic wlc_req_t make_word(logic [1:0] t, logic [7:0] r, logic [31:0] k,
                                           logic [31:0] v, logic [19:0] b);
        wlc_req_t q;
        q.req_type = t;
        q.text_present = 1'b1;
        q.role_id = r;
        q.text_color = {24'h0, r} ^ 32'h5a5a0000;
        q.text_key = k;
        q.value_handle = v;
        q.entry_bytes = b;
        return q;
    endfunction

    // keys drawn from a small pool so gets and puts hit often
    function automatic wlc_req_t rand_word();
        wlc_req_t q;
        int p;
        p = $urandom_range(99);
        q = make_word(p < 45 ? REQ_PUT :
                      (p < 92 ? REQ_GET : (p < 96 ? REQ_CLEAR : REQ_RESERVED)),
                      8'($urandom_range(5)), 32'($urandom_range(7)), $urandom,
                      ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(4000)));
        if ($urandom_range(19) == 0)
        begin
            q.role_id = 8'($urandom);
            q.text_color = $urandom;
            q.text_key = $urandom;
        end
        if ($urandom_range(14) == 0)
            q.text_present = 1'b0;
        if ($urandom_range(7) == 0)
            q.value_handle = 32'($urandom_range(3));
        return q;
    endfunction

    task automatic test_directed();
        wlc_req_t q;
        send_word(make_word(REQ_GET, 8'hff, 32'hffffffff, 32'h0, 20'h0));
        send_word(make_word(REQ_PUT, 8'hff, 32'hffffffff, 32'hffffffff, 20'd65536));
        send_word(make_word(REQ_GET, 8'hff, 32'hffffffff, 32'h0, 20'h0));
        send_word(make_word(REQ_PUT, 8'h0, 32'h0, 32'h1, 20'd65537));
        q = make_word(REQ_PUT, 8'h1, 32'h1, 32'h2, 20'd10);
        q.text_present = 1'b0;
        send_word(q);
        q.req_type = REQ_GET;
        send_word(q);
        send_word(make_word(REQ_PUT, 8'h0, 32'h0, 32'h0, 20'd100));
        send_word(make_word(REQ_PUT, 8'h0, 32'h0, 32'h0, 20'd200));
        send_word(make_word(REQ_PUT, 8'h0, 32'h0, 32'h7, 20'd0));
        send_word(make_word(REQ_RESERVED, 8'h3, 32'h3, 32'h3, 20'hfffff));
        send_word(make_word(REQ_PUT, 8'h2, 32'h2, 32'h8, 20'd65000));
        send_word(make_word(REQ_CLEAR, 8'h0, 32'h0, 32'h0, 20'h0));
        send_word(make_word(REQ_CLEAR, 8'h0, 32'h0, 32'h0, 20'h0));
    endtask

    task automatic test_full_cache();
        // one more than the slot count forces a slot eviction
        for (int i = 0; i <= ENTRIES; i++)
            send_word(make_word(REQ_PUT, 8'(i), 32'(i), 32'(i + 100), 20'd1));
        send_word(make_word(REQ_GET, 8'd5, 32'd5, 32'h0, 20'h0));
        set_limit(20'd3);
        send_word(make_word(REQ_PUT, 8'd5, 32'd5, 32'd999, 20'd1));
        send_word(make_word(REQ_CLEAR, 8'h0, 32'h0, 32'h0, 20'h0));
    endtask

    task automatic test_random(int n, logic [19:0] l);
        set_limit(l);
        for (int i = 0; i < n; i++)
            send_word(rand_word());
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        idle_pct = 29;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        lim = LIMIT_RESET;
        m_total = '0;
        m_count = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            m_valid[i] = 1'b0;
            m_rank[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_cache();
        test_random(70, 20'd8000);
        idle_pct = 81;
        test_random(60, 20'hfffff);
        test_random(30, 20'd0);
        idle_pct = 0;
        test_random(70, 20'd5000);
        wait_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
